### hw/rtl/crc_pkg.sv
package crc_pkg;

    localparam int COORD_W = 19;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 9;
    localparam int FRAC_W  = 8;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    localparam logic [CHAR_W-1:0] CH_FILLED  = 8'h43;
    localparam logic [CHAR_W-1:0] CH_OUTLINE = 8'h63;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 9'd1;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 9'd1;
    localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

    localparam int ONE_Q8 = 256;

endpackage

### hw/rtl/crc_dist.sv
module crc_dist
    import crc_pkg::*;
#(
    parameter int DXW = 20,
    parameter int AW  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [AW-1:0]         i_addr,
    input  logic signed [DXW-1:0] i_dx,
    input  logic signed [DXW-1:0] i_dy,
    output logic                  o_valid,
    output logic [AW-1:0]         o_addr,
    output logic [2*DXW:0]        o_d2,
    output logic                  o_busy
);

    localparam int SQW = 2 * DXW;
    localparam int D2W = SQW + 1;

    logic                  r_va;
    logic                  r_vb;
    logic                  r_vc;
    logic [AW-1:0]         r_addr_a;
    logic [AW-1:0]         r_addr_b;
    logic [AW-1:0]         r_addr_c;
    logic signed [DXW-1:0] r_dx;
    logic signed [DXW-1:0] r_dy;
    logic [SQW-1:0]        r_dx2;
    logic [SQW-1:0]        r_dy2;
    logic [D2W-1:0]        r_d2;
    logic signed [SQW-1:0] dx_sq;
    logic signed [SQW-1:0] dy_sq;

    assign dx_sq = r_dx * r_dx;
    assign dy_sq = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_a <= i_addr;
        r_dx     <= i_dx;
        r_dy     <= i_dy;
        r_addr_b <= r_addr_a;
        r_dx2    <= dx_sq;
        r_dy2    <= dy_sq;
        r_addr_c <= r_addr_b;
        r_d2     <= D2W'(r_dx2) + D2W'(r_dy2);
    end

    assign o_valid = r_vc;
    assign o_addr  = r_addr_c;
    assign o_d2    = r_d2;
    assign o_busy  = r_va | r_vb | r_vc;

endmodule

### hw/rtl/circle_raster_canvas.sv
// Character canvas with a filled and outline circle rasterizer.
// Commands enter on start while busy is low: clear, draw or read. Each
// command gives exactly one result, shown for one cycle with o_valid high;
// the receiver takes it in that cycle and cannot hold it off.
// Configuration (width, height, background) goes over the cfg channel,
// which is always ready; write it only while no command is in flight.
// A rejected draw, a draw with a negative radius and an unused op are
// answered from idle without busy going high; a read passes S_RD1 and
// S_RD2 before its result. A clear or draw sweeps every pixel in use,
// at most one memory write per cycle; the distance pipeline behind the
// sweep drains before the result is shown.
// Commands are taken one at a time; busy stays high until the result cycle,
// in which the next command may already be transferred.
// Reset clears the control and configuration registers; the canvas memory
// is not cleared and holds garbage until a clear or draw covers it.
module circle_raster_canvas
    import crc_pkg::*;
#(
    parameter int MAX_DIM = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_op,
    input  logic [CHAR_W-1:0]         i_shape_type,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_radius,
    input  logic [CHAR_W-1:0]         i_draw_char,
    input  logic [7:0]                i_pixel_col,
    input  logic [7:0]                i_pixel_row,
    output logic                      o_valid,
    output logic                      o_status,
    output logic [CHAR_W-1:0]         o_pixel_char,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DXW   = ((CW + FRAC_W > COORD_W - 1) ? CW + FRAC_W : COORD_W - 1) + 2;
    localparam int SQW   = 2 * DXW;
    localparam int D2W   = SQW + 1;
    localparam int AEW   = AW + 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SWEEP,
        S_DRAIN,
        S_RD1,
        S_RD2
    } t_state;

    typedef enum logic [1:0] {
        M_CLEAR,
        M_FILLED,
        M_OUTLINE
    } t_mode;

    t_state                r_state;
    t_mode                 r_mode;
    logic                  r_valid;
    logic                  r_status;
    logic [CHAR_W-1:0]     r_pix;
    logic [CFG_W-1:0]      r_width;
    logic [CFG_W-1:0]      r_height;
    logic [CHAR_W-1:0]     r_bg;
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         r_row;
    logic [AW-1:0]         r_base;
    logic [CHAR_W-1:0]     r_char;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [DXW-1:0] r_rad;
    logic signed [DXW-1:0] r_inner;
    logic [D2W-1:0]        r_r2;
    logic [D2W-1:0]        r_i2;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_rd_ok;
    logic [CHAR_W-1:0]     r_rd_data;
    logic [CHAR_W-1:0]     r_mem [DEPTH];

    logic [DW-1:0]         w_eff;
    logic [DW-1:0]         h_eff;
    logic                  col_last;
    logic                  row_last;
    logic                  accept;
    logic                  rejected;
    logic [AEW-1:0]        rd_full;
    logic signed [DXW-1:0] n_dx;
    logic signed [DXW-1:0] n_dy;
    logic signed [SQW-1:0] rad_sq;
    logic signed [SQW-1:0] inner_sq;
    logic                  pipe_valid;
    logic [AW-1:0]         pipe_addr;
    logic [D2W-1:0]        pipe_d2;
    logic                  pipe_busy;
    logic                  hit;
    logic                  w_en;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;

    assign w_eff = (r_width == '0) ? DW'(1) :
                   ((32'(r_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_width));
    assign h_eff = (r_height == '0) ? DW'(1) :
                   ((32'(r_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_height));

    assign col_last = (32'(r_col) + 1 == 32'(w_eff));
    assign row_last = (32'(r_row) + 1 == 32'(h_eff));

    assign rejected = ((i_shape_type != CH_FILLED) && (i_shape_type != CH_OUTLINE)) ||
                      (i_radius == '0) || (i_draw_char == CH_NUL) ||
                      (i_draw_char == CH_NL);

    assign rd_full = AEW'(i_pixel_row) * AEW'(MAX_DIM) + AEW'(i_pixel_col);

    assign n_dx = DXW'($signed({1'b0, r_col, 8'h00})) - DXW'(r_cx);
    assign n_dy = DXW'($signed({1'b0, r_row, 8'h00})) - DXW'(r_cy);

    assign rad_sq   = r_rad * r_rad;
    assign inner_sq = r_inner * r_inner;

    crc_dist #(
        .DXW (DXW),
        .AW  (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_state == S_SWEEP),
        .i_addr  (r_base + AW'(r_col)),
        .i_dx    (n_dx),
        .i_dy    (n_dy),
        .o_valid (pipe_valid),
        .o_addr  (pipe_addr),
        .o_d2    (pipe_d2),
        .o_busy  (pipe_busy)
    );

    always_comb begin
        case (r_mode)
            M_CLEAR:   hit = 1'b1;
            M_FILLED:  hit = (pipe_d2 <= r_r2);
            M_OUTLINE: hit = (pipe_d2 < r_r2) && (r_inner[DXW-1] || (pipe_d2 > r_i2));
            default:   hit = 1'b0;
        endcase
    end

    assign w_en = pipe_valid && hit;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[pipe_addr] <= r_char;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_bg     <= BG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_BG:     r_bg     <= i_cfg_data[CHAR_W-1:0];
                default:    r_bg     <= r_bg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_CLEAR;
            r_valid  <= 1'b0;
            r_status <= 1'b0;
            r_pix    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_base   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= 1'b0;
                        r_pix    <= '0;
                        r_col    <= '0;
                        r_row    <= '0;
                        r_base   <= '0;
                        case (i_op)
                            OP_CLEAR: begin
                                r_mode  <= M_CLEAR;
                                r_state <= S_SWEEP;
                            end
                            OP_DRAW: begin
                                r_mode <= (i_shape_type == CH_FILLED) ? M_FILLED : M_OUTLINE;
                                if (rejected) begin
                                    r_status <= 1'b1;
                                    r_valid  <= 1'b1;
                                end else if (i_radius[COORD_W-1]) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_state <= S_SETUP;
                                end
                            end
                            OP_READ: begin
                                r_state <= S_RD1;
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (col_last) begin
                        r_col  <= '0;
                        r_base <= r_base + AW'(MAX_DIM);
                        if (row_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_row <= r_row + CW'(1);
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_pix   <= r_rd_ok ? r_rd_data : '0;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_r2 <= D2W'(rad_sq);
            r_i2 <= D2W'(inner_sq);
        end
        if (accept) begin
            r_char    <= (i_op == OP_CLEAR) ? r_bg : i_draw_char;
            r_cx      <= i_center_x;
            r_cy      <= i_center_y;
            r_rad     <= DXW'(i_radius);
            r_inner   <= DXW'(i_radius) - DXW'(ONE_Q8);
            r_rd_addr <= rd_full[AW-1:0];
            r_rd_ok   <= (32'(i_pixel_col) < 32'(w_eff)) && (32'(i_pixel_row) < 32'(h_eff));
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_pixel_char = r_pix;

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted command neither started nor answered");

    a_reject_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_pixel_char == '0))
        else $error("rejected draw carries a pixel");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("canvas written outside a sweep");

endmodule

### sim/circle_raster_canvas_checker.sv
`timescale 1ns / 1ps

module circle_raster_canvas_checker
    import crc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [1:0]                i_op,
    input  logic [CHAR_W-1:0]         i_shape_type,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_radius,
    input  logic [CHAR_W-1:0]         i_draw_char,
    input  logic [7:0]                i_pixel_col,
    input  logic [7:0]                i_pixel_row,
    input  logic                      i_result_valid,
    input  logic                      i_status,
    input  logic [CHAR_W-1:0]         i_pixel_char,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    localparam int CANVAS_DIM = 256;

    typedef struct packed {
        logic              status;
        logic [CHAR_W-1:0] pixel_char;
    } t_reply;

    logic [CHAR_W-1:0] canvas_copy [CANVAS_DIM * CANVAS_DIM];
    logic [CFG_W-1:0]  width_reg  = WIDTH_RST;
    logic [CFG_W-1:0]  height_reg = HEIGHT_RST;
    logic [CHAR_W-1:0] bg_reg     = BG_RST;
    t_reply            replies_due [$];
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int clamp_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > CANVAS_DIM) return CANVAS_DIM;
        return int'(v);
    endfunction

    function automatic t_reply apply_canvas_command(
        logic [1:0]                op,
        logic [CHAR_W-1:0]         shape,
        logic signed [COORD_W-1:0] center_x,
        logic signed [COORD_W-1:0] center_y,
        logic signed [COORD_W-1:0] radius,
        logic [CHAR_W-1:0]         paint,
        logic [7:0]                col,
        logic [7:0]                row
    );
        t_reply answer;
        int     w, h, x, y;
        longint cx, cy, rad, inner, r2, i2, dx, dy, d2;
        bit     hit;
        answer = '0;
        w      = clamp_dim(width_reg);
        h      = clamp_dim(height_reg);
        cx     = longint'(center_x);
        cy     = longint'(center_y);
        rad    = longint'(radius);
        inner  = rad - ONE_Q8;
        r2     = rad * rad;
        i2     = inner * inner;
        case (op)
            OP_CLEAR: begin
                for (y = 0; y < h; y++)
                    for (x = 0; x < w; x++)
                        canvas_copy[y * CANVAS_DIM + x] = bg_reg;
            end
            OP_DRAW: begin
                if ((shape != CH_FILLED && shape != CH_OUTLINE) || rad == 0 ||
                    paint == CH_NUL || paint == CH_NL) begin
                    answer.status = 1'b1;
                end else if (rad > 0) begin
                    for (y = 0; y < h; y++) begin
                        dy = longint'(y) * ONE_Q8 - cy;
                        for (x = 0; x < w; x++) begin
                            dx = longint'(x) * ONE_Q8 - cx;
                            d2 = dx * dx + dy * dy;
                            if (shape == CH_FILLED)
                                hit = d2 <= r2;
                            else
                                hit = d2 < r2 && (inner < 0 || d2 > i2);
                            if (hit)
                                canvas_copy[y * CANVAS_DIM + x] = paint;
                        end
                    end
                end
            end
            OP_READ: begin
                if (int'(col) < w && int'(row) < h)
                    answer.pixel_char = canvas_copy[int'(row) * CANVAS_DIM + int'(col)];
            end
            default: begin
            end
        endcase
        return answer;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            bg_reg     = BG_RST;
            replies_due.delete();
        end else begin
            if (i_result_valid) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected result: status %0d pixel_char 0x%02h",
                           i_status, i_pixel_char);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_pixel_char !== want.pixel_char) begin
                        $error("pixel_char: expected 0x%02h, actual 0x%02h",
                               want.pixel_char, i_pixel_char);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  width_reg  = i_cfg_data;
                    CFG_HEIGHT: height_reg = i_cfg_data;
                    CFG_BG:     bg_reg     = i_cfg_data[CHAR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                replies_due.push_back(apply_canvas_command(i_op, i_shape_type, i_center_x,
                    i_center_y, i_radius, i_draw_char, i_pixel_col, i_pixel_row));
            end
        end
        o_outstanding <= replies_due.size();
    end

endmodule

### sim/tb_circle_raster_canvas.sv
`timescale 1ns / 1ps

module tb_circle_raster_canvas
    import crc_pkg::*;
;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                      i_clk;
    logic                      i_rst_n      = 1'b0;
    logic                      start        = 1'b0;
    logic                      busy;
    logic [1:0]                i_op         = OP_CLEAR;
    logic [CHAR_W-1:0]         i_shape_type = '0;
    logic signed [COORD_W-1:0] i_center_x   = '0;
    logic signed [COORD_W-1:0] i_center_y   = '0;
    logic signed [COORD_W-1:0] i_radius     = '0;
    logic [CHAR_W-1:0]         i_draw_char  = '0;
    logic [7:0]                i_pixel_col  = '0;
    logic [7:0]                i_pixel_row  = '0;
    logic                      o_valid;
    logic                      o_status;
    logic [CHAR_W-1:0]         o_pixel_char;
    logic                      i_cfg_valid  = 1'b0;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index  = CFG_WIDTH;
    logic [CFG_W-1:0]          i_cfg_data   = '0;

    int          fail_count;
    int          outstanding;
    int          eff_w       = 1;
    int          eff_h       = 1;
    int          idle_pct    = 0;
    int unsigned cycle_count = 0;

    circle_raster_canvas dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_shape_type (i_shape_type),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_draw_char  (i_draw_char),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_pixel_char (o_pixel_char),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    circle_raster_canvas_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_op           (i_op),
        .i_shape_type   (i_shape_type),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_draw_char    (i_draw_char),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_result_valid (o_valid),
        .i_status       (o_status),
        .i_pixel_char   (o_pixel_char),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_command(
        input logic [1:0]                op,
        input logic [CHAR_W-1:0]         shape,
        input logic signed [COORD_W-1:0] cx,
        input logic signed [COORD_W-1:0] cy,
        input logic signed [COORD_W-1:0] r,
        input logic [CHAR_W-1:0]         ch,
        input logic [7:0]                col,
        input logic [7:0]                row
    );
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_shape_type <= shape;
        i_center_x   <= cx;
        i_center_y   <= cy;
        i_radius     <= r;
        i_draw_char  <= ch;
        i_pixel_col  <= col;
        i_pixel_row  <= row;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input int w, input int h, input int bg);
        wait_for_replies();
        repeat (8) @(posedge i_clk);
        write_register(CFG_WIDTH, CFG_W'(w));
        write_register(CFG_HEIGHT, CFG_W'(h));
        write_register(CFG_BG, CFG_W'(bg));
        i_cfg_valid <= 1'b0;
        eff_w = (w < 1) ? 1 : (w > 256) ? 256 : w;
        eff_h = (h < 1) ? 1 : (h > 256) ? 256 : h;
    endtask

    function automatic logic [1:0] pick_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return OP_CLEAR;
        if (pick < 52) return OP_DRAW;
        if (pick < 95) return OP_READ;
        return OP_UNUSED;
    endfunction

    task automatic send_random_item(input logic [1:0] op);
        logic [CHAR_W-1:0]         shape, ch;
        logic [7:0]                col, row;
        logic signed [COORD_W-1:0] cx, cy, r;
        int                        pick, reach;
        shape = CHAR_W'($urandom);
        ch    = CHAR_W'($urandom);
        col   = 8'($urandom);
        row   = 8'($urandom);
        cx    = COORD_W'($urandom);
        cy    = COORD_W'($urandom);
        r     = COORD_W'($urandom);
        reach = (eff_w > eff_h ? eff_w : eff_h) * ONE_Q8;
        if (op == OP_DRAW) begin
            pick = $urandom_range(99);
            if (pick < 46)
                shape = CH_FILLED;
            else if (pick < 92)
                shape = CH_OUTLINE;
            if ($urandom_range(9) != 0) begin
                cx = COORD_W'($urandom_range(eff_w * ONE_Q8 + 2 * ONE_Q8) - ONE_Q8);
                cy = COORD_W'($urandom_range(eff_h * ONE_Q8 + 2 * ONE_Q8) - ONE_Q8);
            end
            pick = $urandom_range(99);
            if (pick < 4)
                r = '0;
            else if (pick < 14)
                r = COORD_W'(0 - $urandom_range(1, 4 * ONE_Q8));
            else if (pick < 28)
                r = COORD_W'($urandom_range(1, ONE_Q8 - 1));
            else if (pick < 88)
                r = COORD_W'($urandom_range(ONE_Q8 / 2, reach));
            pick = $urandom_range(99);
            if (pick < 4)
                ch = CH_NUL;
            else if (pick < 8)
                ch = CH_NL;
            else
                while (ch == CH_NUL || ch == CH_NL) ch = CHAR_W'($urandom);
        end else if (op == OP_READ && $urandom_range(4) != 0) begin
            col = 8'($urandom_range(eff_w - 1));
            row = 8'($urandom_range(eff_h - 1));
        end
        send_command(op, shape, cx, cy, r, ch, col, row);
    endtask

    int phase_w    [6] = '{0, 511, 13, 16, 5, 3};
    int phase_h    [6] = '{16, 1, 9, 16, 0, 11};
    int phase_idle [6] = '{0, 79, 12, 79, 12, 0};

    initial begin
        int phase, n, bg;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset-size canvas
        send_command(OP_CLEAR, '0, '0, '0, '0, '0, 8'd0, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd0, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd1, 8'd0);

        configure(8, 6, int'(8'h2E));
        send_command(OP_CLEAR, '0, '0, '0, '0, '0, 8'd0, 8'd0);
        send_command(OP_DRAW, CH_FILLED, COORD_W'(3 * ONE_Q8 + ONE_Q8 / 2),
                     COORD_W'(2 * ONE_Q8 + ONE_Q8 / 2), COORD_W'(2 * ONE_Q8), 8'h23,
                     8'd0, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd3, 8'd2);
        send_command(OP_DRAW, CH_OUTLINE, COORD_W'(3 * ONE_Q8), COORD_W'(3 * ONE_Q8),
                     COORD_W'(3 * ONE_Q8), 8'h6F, 8'd0, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd0, 8'd3);
        send_command(OP_DRAW, CH_OUTLINE, COORD_W'(ONE_Q8), COORD_W'(ONE_Q8),
                     COORD_W'(ONE_Q8 / 2), 8'h2A, 8'd0, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd1, 8'd1);
        send_command(OP_DRAW, CH_FILLED, COORD_W'(ONE_Q8), COORD_W'(ONE_Q8),
                     COORD_W'(-ONE_Q8), 8'h78, 8'd0, 8'd0);
        send_command(OP_DRAW, CH_FILLED, COORD_W'(ONE_Q8), COORD_W'(ONE_Q8), '0, 8'h41,
                     8'd0, 8'd0);
        send_command(OP_DRAW, CH_FILLED, COORD_W'(ONE_Q8), COORD_W'(ONE_Q8),
                     COORD_W'(2 * ONE_Q8), CH_NUL, 8'd0, 8'd0);
        send_command(OP_DRAW, CH_OUTLINE, COORD_W'(ONE_Q8), COORD_W'(ONE_Q8),
                     COORD_W'(2 * ONE_Q8), CH_NL, 8'd0, 8'd0);
        send_command(OP_DRAW, 8'h58, COORD_W'(ONE_Q8), COORD_W'(ONE_Q8),
                     COORD_W'(2 * ONE_Q8), 8'h41, 8'd0, 8'd0);
        send_command(OP_DRAW, 8'hFF, COORD_MIN, COORD_MIN, COORD_MIN, 8'hFF, 8'd0, 8'd0);
        send_command(OP_DRAW, CH_FILLED, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF,
                     8'd0, 8'd0);
        send_command(OP_DRAW, CH_OUTLINE, COORD_MIN, COORD_MIN, COORD_MAX, 8'h01,
                     8'd0, 8'd0);
        send_command(OP_DRAW, CH_FILLED, '0, '0, COORD_MAX, 8'hFE, 8'd0, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd7, 8'd5);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd8, 8'd0);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd0, 8'd6);
        send_command(OP_READ, '0, '0, '0, '0, '0, 8'd255, 8'd255);
        send_command(OP_UNUSED, 8'hFF, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF,
                     8'hFF, 8'hFF);

        for (phase = 0; phase < 6; phase++) begin
            bg = (phase == 0) ? 255 : (phase == 1) ? 1 : $urandom_range(1, 255);
            configure(phase_w[phase], phase_h[phase], bg);
            idle_pct = phase_idle[phase];
            send_random_item(OP_CLEAR);
            for (n = 1; n < 12; n++) begin
                send_random_item(pick_op());
                if (phase == 2 && n == 8)
                    wait_for_replies();
            end
        end

        // full-size canvas: few sweeps, since each one covers every pixel
        configure(256, 256, $urandom_range(1, 255));
        idle_pct = 12;
        send_random_item(OP_CLEAR);
        send_random_item(OP_DRAW);
        send_random_item(OP_DRAW);
        for (n = 0; n < 8; n++)
            send_random_item(OP_READ);
        send_random_item(OP_UNUSED);

        wait_for_replies();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
